### src/bpk_pkg.sv
// Shared types and constants for the LSB-first bit packer.
package bpk_pkg;

    // Default largest field length accepted before the count saturates.
    localparam int DEF_MAX_FIELD_BITS = 32;

    // Width of the hardware field path (field_value width).
    localparam int FIELD_W = 32;

    // Pending bits (up to 7) plus one full field.
    localparam int ACC_W = FIELD_W + 7;

    localparam int BYTE_W = 8;

    // Input kind carried in tuser.
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } bpk_state_t;

    // Controls from the sequencer to the shift unit.
    typedef struct packed {
        logic load;
        logic shift;
    } bpk_ctrl_t;

    // Status from the shift unit back to the sequencer.
    typedef struct packed {
        logic [5:0] n_eff;
        logic [2:0] load_bytes;
        logic [2:0] cur_bytes;
        logic [2:0] pend_count;
        logic [7:0] low_byte;
    } bpk_stat_t;

endpackage

### src/lsb_first_bit_packer.sv
// Top level of the LSB-first variable-length bit packer.
//
//   Channel  Direction  tdata (low bit up)                  tuser / tlast
//   s_       in         field_value[31:0], bit_count[37:32]  tuser = func
//   m_       out        out_byte[7:0], bit_position[39:8]    tlast = last
//
// An input word is taken only while the sequencer is idle. An append or a
// flush then completes N bytes (0 to 4), and the shift unit hands one byte a
// cycle to the output register while that register can take it. A word that
// completes no byte leaves the sequencer idle.
// Reset is synchronous and active low; it clears the pending bits, the bit
// head and the output valid flag, but not the output byte, position or last flag.
// A stalled m_ side holds the byte in the output register and pauses the
// shifter; the last byte of a word may wait there while the next word is taken.
module lsb_first_bit_packer import bpk_pkg::*; #(
    parameter int MAX_FIELD_BITS = DEF_MAX_FIELD_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // field_value[31:0], bit_count[37:32], zero pad
    input  logic        s_tuser,   // func: 0 append, 1 flush
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_byte[7:0], bit_position[39:8]
    output logic        m_tlast
);

    bpk_state_t state_reg, state_next;
    bpk_ctrl_t  ctrl;
    bpk_stat_t  stat;

    logic        s_fire;
    logic        out_load;

    logic [31:0] bit_head_reg, bit_head_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_byte_reg;
    logic        m_last_reg;
    logic [31:0] m_pos_reg;

    assign s_fire = s_tvalid && s_tready;

    // The shift unit doubles as the pending-bit store between words.
    bpk_shift_unit #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_shift (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .func        (s_tuser),
        .field_value (s_tdata[31:0]),
        .bit_count   (s_tdata[37:32]),
        .stat        (stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencer: load the accumulator on an accepted word, then shift one
    // byte out per cycle whenever the output register can take it.
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        ctrl.load  = 1'b0;
        ctrl.shift = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                ctrl.load = s_tvalid;
                if (s_tvalid && stat.load_bytes != 3'd0) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    ctrl.shift = 1'b1;
                    if (stat.cur_bytes == 3'd1) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The bit head counts appended bits only; flush padding is not counted.
    always_comb begin
        bit_head_next = bit_head_reg;
        if (s_fire && s_tuser == FUNC_APPEND) begin
            bit_head_next = bit_head_reg + 32'(stat.n_eff);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_head_reg <= 32'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            bit_head_reg <= bit_head_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_byte_reg <= stat.low_byte;
            m_last_reg <= (stat.cur_bytes == 3'd1);
            m_pos_reg  <= bit_head_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_pos_reg, m_byte_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTH
    // While emitting there is always at least one byte left in the shifter.
    a_emit_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> stat.cur_bytes != 3'd0)
        else $error("emit state with no bytes left");

    // Back in idle, every completed byte has been handed out.
    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> stat.cur_bytes == 3'd0)
        else $error("idle with bytes still pending");

    // Pending bits above the pending count stay zero, so a flush pads with zeros.
    a_pending_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> (stat.low_byte >> stat.pend_count) == 8'd0)
        else $error("stale bits above the pending count");

    // An append advances the bit head by the saturated field length.
    a_head_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tuser == FUNC_APPEND |=>
            bit_head_reg == $past(bit_head_reg) + 32'($past(stat.n_eff)))
        else $error("bit head did not advance by the field length");
`endif

endmodule

### src/bpk_shift_unit.sv
// Accumulator and byte shifter that holds the pending bits of the packer.
module bpk_shift_unit import bpk_pkg::*; #(
    parameter int MAX_FIELD_BITS = DEF_MAX_FIELD_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bpk_ctrl_t           ctrl,
    input  logic                func,
    input  logic [FIELD_W-1:0]  field_value,
    input  logic [5:0]          bit_count,
    output bpk_stat_t           stat
);

    localparam int CAP = (MAX_FIELD_BITS < FIELD_W) ? MAX_FIELD_BITS : FIELD_W;
    localparam logic [5:0] CAP_N = 6'(CAP);

    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [2:0]         pc_reg, pc_next;
    logic [2:0]         bytes_reg, bytes_next;

    logic [5:0]         n_eff;
    logic [FIELD_W:0]   mask_wide;
    logic [FIELD_W-1:0] masked;
    logic [ACC_W-1:0]   shifted;
    logic [5:0]         total;
    logic [2:0]         load_bytes;

    always_comb begin
        n_eff     = (bit_count > CAP_N) ? CAP_N : bit_count;
        mask_wide = ((FIELD_W+1)'(1) << n_eff) - (FIELD_W+1)'(1);
        masked    = field_value & mask_wide[FIELD_W-1:0];
        shifted   = ACC_W'(masked) << pc_reg;
        total     = {3'b000, pc_reg} + n_eff;
        if (func == FUNC_FLUSH) begin
            load_bytes = (pc_reg != 3'd0) ? 3'd1 : 3'd0;
        end else begin
            load_bytes = total[5:3];
        end
    end

    always_comb begin
        acc_next   = acc_reg;
        pc_next    = pc_reg;
        bytes_next = bytes_reg;
        if (ctrl.load) begin
            bytes_next = load_bytes;
            if (func == FUNC_FLUSH) begin
                pc_next = 3'd0;
            end else begin
                acc_next = acc_reg | shifted;
                pc_next  = total[2:0];
            end
        end else if (ctrl.shift) begin
            acc_next   = acc_reg >> BYTE_W;
            bytes_next = bytes_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            pc_reg    <= 3'd0;
            bytes_reg <= 3'd0;
        end else begin
            acc_reg   <= acc_next;
            pc_reg    <= pc_next;
            bytes_reg <= bytes_next;
        end
    end

    always_comb begin
        stat.n_eff      = n_eff;
        stat.load_bytes = load_bytes;
        stat.cur_bytes  = bytes_reg;
        stat.pend_count = pc_reg;
        stat.low_byte   = acc_reg[BYTE_W-1:0];
    end

endmodule
